@@ rtl/ttcb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcb_pkg: shared definitions for the text terminal cell buffer
// Screen geometry, character codes, transaction kinds and the state type.
// ----------------------------------------------------------------------------
package ttcb_pkg;

   // Screen geometry
   localparam int COLS        = 80;
   localparam int ROWS        = 25;
   localparam int SCREEN_SIZE = ROWS * COLS;
   localparam int CELL_AW     = $clog2(SCREEN_SIZE);
   localparam int COL_W       = $clog2(COLS);
   localparam int CHAR_W      = 8;
   localparam int ADDR_FIELD_W = 11;
   localparam int TAB_SPACES  = 4;
   localparam int TAB_W       = $clog2(TAB_SPACES + 1);

   typedef logic [CHAR_W-1:0]       char_type;
   typedef logic [CELL_AW-1:0]      cell_addr_type;
   typedef logic [CELL_AW:0]        cell_sum_type;
   typedef logic [COL_W-1:0]        col_type;
   typedef logic [TAB_W-1:0]        tab_count_type;
   typedef logic [ADDR_FIELD_W-1:0] addr_field_type;

   // Character codes with console meaning
   localparam char_type CH_BACKSPACE = 8'd8;
   localparam char_type CH_TAB       = 8'd9;
   localparam char_type CH_NEWLINE   = 8'd10;
   localparam char_type CH_RETURN    = 8'd13;
   localparam char_type CH_SPACE     = 8'd32;
   localparam char_type CH_NUL       = 8'd0;

   // Transaction kinds
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

@@ rtl/text_terminal_cell_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_unit: character-cell console screen with scroll
//
// Input channel (req_): one transaction is either a put of req_char_code at
// the cursor (req_kind = 0) or a read of the cell at req_cell_address
// (req_kind = 1). Backspace, tab, newline and carriage return act as on a
// console. Result channel (rsp_): one transaction per input transaction with
// the cell byte (reads), the cursor after the item and a scroll flag.
// A read inside the screen goes through the registered RAM read; a read past
// its end returns zero without one. A tab writes TAB_SPACES spaces in turn. A
// scroll clears the row that becomes the bottom line; rows live in a ring
// inside one RAM, so no data is moved. The single sequencer takes a new
// transaction only when idle, once the last result has left the sequencer.
// After reset the RAM is swept to zero one cell per cycle, with req_ready
// low. A finished result sits in the output register; the next transaction
// is accepted while it waits, and the following result holds in the
// sequencer until rsp_ready frees the slot.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_value,
   output logic [10:0] rsp_cursor_position,
   output logic        rsp_scrolled
);

   ttcb_pkg::state_type     state_ff, state_in;
   ttcb_pkg::cell_addr_type clear_ff, clear_in;
   ttcb_pkg::cell_addr_type cursor_ff, cursor_in;
   ttcb_pkg::col_type       col_ff, col_in;
   ttcb_pkg::cell_addr_type base_ff, base_in;
   ttcb_pkg::col_type       fill_ff, fill_in;
   ttcb_pkg::tab_count_type tab_left_ff, tab_left_in;
   ttcb_pkg::char_type      value_ff, value_in;
   logic                    scrolled_ff, scrolled_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ttcb_pkg::char_type      rsp_value_ff, rsp_value_in;
   ttcb_pkg::cell_addr_type rsp_cursor_ff, rsp_cursor_in;
   logic                    rsp_scrolled_ff, rsp_scrolled_in;

   logic                    ram_wr_en;
   ttcb_pkg::cell_addr_type ram_wr_addr;
   ttcb_pkg::char_type      ram_wr_data;
   logic                    ram_rd_en;
   ttcb_pkg::cell_addr_type ram_rd_addr;
   ttcb_pkg::char_type      ram_rd_data;

   ttcb_pkg::cell_addr_type line_start;
   ttcb_pkg::cell_sum_type  nl_next;
   logic                    nl_wrap;
   ttcb_pkg::cell_addr_type bs_cursor;
   ttcb_pkg::col_type       bs_col;
   ttcb_pkg::cell_addr_type step_cursor;
   ttcb_pkg::col_type       step_col;
   logic                    step_at_end;
   ttcb_pkg::cell_addr_type cursor_phys;
   ttcb_pkg::cell_addr_type bs_phys;
   ttcb_pkg::cell_addr_type read_phys;
   logic                    read_in_range;
   ttcb_pkg::cell_sum_type  base_next;
   logic                    rsp_free;

   // Map a screen position onto the RAM ring, top row starting at base_ff
   function automatic ttcb_pkg::cell_addr_type to_phys(
      input ttcb_pkg::cell_addr_type pos,
      input ttcb_pkg::cell_addr_type base
   );
      ttcb_pkg::cell_sum_type sum;
      sum = {1'b0, pos} + {1'b0, base};
      if (sum >= ttcb_pkg::cell_sum_type'(ttcb_pkg::SCREEN_SIZE)) begin
         sum = sum - ttcb_pkg::cell_sum_type'(ttcb_pkg::SCREEN_SIZE);
      end
      return ttcb_pkg::cell_addr_type'(sum);
   endfunction

   ttcb_ram #(
      .WIDTH(ttcb_pkg::CHAR_W),
      .DEPTH(ttcb_pkg::SCREEN_SIZE)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Cursor arithmetic for each kind of put
   always_comb begin
      line_start = cursor_ff - ttcb_pkg::cell_addr_type'(col_ff);
      nl_next    = {1'b0, line_start} + ttcb_pkg::cell_sum_type'(ttcb_pkg::COLS);
      nl_wrap    = nl_next >= ttcb_pkg::cell_sum_type'(ttcb_pkg::SCREEN_SIZE);

      bs_cursor = cursor_ff - ttcb_pkg::cell_addr_type'(1);
      bs_col    = (col_ff == '0) ? ttcb_pkg::col_type'(ttcb_pkg::COLS - 1)
                                 : col_ff - ttcb_pkg::col_type'(1);

      step_at_end = cursor_ff == ttcb_pkg::cell_addr_type'(ttcb_pkg::SCREEN_SIZE - 1);
      step_cursor = step_at_end
                    ? ttcb_pkg::cell_addr_type'(ttcb_pkg::SCREEN_SIZE - ttcb_pkg::COLS)
                    : cursor_ff + ttcb_pkg::cell_addr_type'(1);
      step_col    = (col_ff == ttcb_pkg::col_type'(ttcb_pkg::COLS - 1))
                    ? '0 : col_ff + ttcb_pkg::col_type'(1);

      cursor_phys = to_phys(cursor_ff, base_ff);
      bs_phys     = to_phys(bs_cursor, base_ff);

      read_in_range = 32'(req_cell_address) < 32'(ttcb_pkg::SCREEN_SIZE);
      read_phys     = to_phys(ttcb_pkg::cell_addr_type'(req_cell_address), base_ff);

      base_next = {1'b0, base_ff} + ttcb_pkg::cell_sum_type'(ttcb_pkg::COLS);
   end

   // Sequencer: next state, RAM port control and result staging
   always_comb begin
      state_in        = state_ff;
      clear_in        = clear_ff;
      cursor_in       = cursor_ff;
      col_in          = col_ff;
      base_in         = base_ff;
      fill_in         = fill_ff;
      tab_left_in     = tab_left_ff;
      value_in        = value_ff;
      scrolled_in     = scrolled_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = cursor_phys;
      ram_wr_data     = ttcb_pkg::CH_SPACE;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = read_phys;
      req_ready       = 1'b0;

      // Drop the output transaction once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_free = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         ttcb_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_ff;
            ram_wr_data = ttcb_pkg::CH_NUL;
            if (clear_ff == ttcb_pkg::cell_addr_type'(ttcb_pkg::SCREEN_SIZE - 1)) begin
               state_in = ttcb_pkg::ST_IDLE;
            end else begin
               clear_in = clear_ff + ttcb_pkg::cell_addr_type'(1);
            end
         end

         ttcb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               scrolled_in = 1'b0;
               value_in    = ttcb_pkg::CH_NUL;
               tab_left_in = '0;
               fill_in     = '0;
               if (req_kind == ttcb_pkg::KIND_READ) begin
                  if (read_in_range) begin
                     ram_rd_en = 1'b1;
                     state_in  = ttcb_pkg::ST_READ;
                  end else begin
                     state_in  = ttcb_pkg::ST_DONE;
                  end
               end else begin
                  unique case (req_char_code)
                     ttcb_pkg::CH_BACKSPACE: begin
                        if (cursor_ff != '0) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = bs_phys;
                           cursor_in   = bs_cursor;
                           col_in      = bs_col;
                        end
                        state_in = ttcb_pkg::ST_DONE;
                     end
                     ttcb_pkg::CH_NEWLINE: begin
                        col_in = '0;
                        if (nl_wrap) begin
                           cursor_in = line_start;
                           state_in  = ttcb_pkg::ST_SCROLL;
                        end else begin
                           cursor_in = ttcb_pkg::cell_addr_type'(nl_next);
                           state_in  = ttcb_pkg::ST_DONE;
                        end
                     end
                     ttcb_pkg::CH_RETURN: begin
                        cursor_in = line_start;
                        col_in    = '0;
                        state_in  = ttcb_pkg::ST_DONE;
                     end
                     ttcb_pkg::CH_TAB: begin
                        tab_left_in = ttcb_pkg::tab_count_type'(ttcb_pkg::TAB_SPACES);
                        state_in    = ttcb_pkg::ST_PUT;
                     end
                     default: begin
                        // Store any other byte and advance
                        ram_wr_en   = 1'b1;
                        ram_wr_data = req_char_code;
                        cursor_in   = step_cursor;
                        col_in      = step_col;
                        state_in    = step_at_end ? ttcb_pkg::ST_SCROLL
                                                  : ttcb_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end

         ttcb_pkg::ST_PUT: begin
            // One tab space per cycle, paused while a scroll clears a row
            ram_wr_en   = 1'b1;
            cursor_in   = step_cursor;
            col_in      = step_col;
            tab_left_in = tab_left_ff - ttcb_pkg::tab_count_type'(1);
            if (step_at_end) begin
               state_in = ttcb_pkg::ST_SCROLL;
            end else if (tab_left_ff == ttcb_pkg::tab_count_type'(1)) begin
               state_in = ttcb_pkg::ST_DONE;
            end
         end

         ttcb_pkg::ST_SCROLL: begin
            // Blank the old top row, then make it the bottom row
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + ttcb_pkg::cell_addr_type'(fill_ff);
            if (fill_ff == ttcb_pkg::col_type'(ttcb_pkg::COLS - 1)) begin
               fill_in     = '0;
               scrolled_in = 1'b1;
               if (base_next >= ttcb_pkg::cell_sum_type'(ttcb_pkg::SCREEN_SIZE)) begin
                  base_in = '0;
               end else begin
                  base_in = ttcb_pkg::cell_addr_type'(base_next);
               end
               state_in = (tab_left_ff != '0) ? ttcb_pkg::ST_PUT : ttcb_pkg::ST_DONE;
            end else begin
               fill_in = fill_ff + ttcb_pkg::col_type'(1);
            end
         end

         ttcb_pkg::ST_READ: begin
            value_in = ram_rd_data;
            state_in = ttcb_pkg::ST_DONE;
         end

         ttcb_pkg::ST_DONE: begin
            // Hand the result to the output register when it is free
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = value_ff;
               rsp_cursor_in   = cursor_ff;
               rsp_scrolled_in = scrolled_ff;
               state_in        = ttcb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ttcb_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttcb_pkg::ST_CLEAR;
         clear_ff     <= '0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         fill_ff      <= '0;
         tab_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         tab_left_ff  <= tab_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      scrolled_ff     <= scrolled_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_value_ff;
   assign rsp_cursor_position = ttcb_pkg::addr_field_type'(rsp_cursor_ff);
   assign rsp_scrolled        = rsp_scrolled_ff;

endmodule

@@ rtl/ttcb_ram.sv @@
// ----------------------------------------------------------------------------
// ttcb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/text_terminal_cell_buffer_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_unit_test: console screen buffer testbench
//
// Sends put and read transactions into the request channel and keeps its own
// copy of the screen and cursor to predict each response. A checker compares
// every response, field by field, with the oldest prediction. Both channels
// idle at random, and the response side holds off for a long stretch to fill
// the block and stall its input.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer_unit_test;
   import ttcb_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int IDLE_PERCENT  = 6;
   localparam int HOLD_OFF_LEN  = 400;
   localparam addr_field_type ADDR_FIELD_MAX = '1;

   typedef struct packed {
      char_type       cell_value;
      addr_field_type cursor_position;
      logic           scrolled;
   } cell_result_type;

   logic           clock            = 1'b0;
   logic           reset            = 1'b1;
   logic           req_valid        = 1'b0;
   logic           req_ready;
   logic           req_kind         = KIND_PUT;
   char_type       req_char_code    = CH_NUL;
   addr_field_type req_cell_address = '0;
   logic           rsp_valid;
   logic           rsp_ready        = 1'b0;
   logic [7:0]     rsp_cell_value;
   logic [10:0]    rsp_cursor_position;
   logic           rsp_scrolled;

   // Mirror of the screen, the cursor and the responses still owed
   char_type        screen_image [SCREEN_SIZE];
   int unsigned     cursor_pos;
   cell_result_type pending_results [$];
   int              error_count     = 0;
   int              items_sent      = 0;
   int              hold_off_cycles = 0;
   int              cycle_count     = 0;
   bit              idle_on         = 1'b1;

   text_terminal_cell_buffer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_cell_address    (req_cell_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled)
   );

   always #CLOCK_HALF clock = ~clock;

   // Move every row up one and blank the bottom row once the cursor runs off
   function automatic void scroll_if_past_end(inout logic hit);
      if (cursor_pos >= SCREEN_SIZE) begin
         for (int i = 0; i < SCREEN_SIZE - COLS; i++)
            screen_image[i] = screen_image[i + COLS];
         for (int i = SCREEN_SIZE - COLS; i < SCREEN_SIZE; i++)
            screen_image[i] = CH_SPACE;
         cursor_pos -= COLS;
         hit = 1'b1;
      end
   endfunction

   // Store one byte at the cursor and advance
   function automatic void store_char(input char_type ch, inout logic hit);
      if (cursor_pos < SCREEN_SIZE)
         screen_image[cursor_pos] = ch;
      cursor_pos++;
      scroll_if_past_end(hit);
   endfunction

   // Apply one transaction to the mirror and return the response it causes
   function automatic cell_result_type console_step(input logic kind, input char_type ch,
                                                    input addr_field_type addr);
      cell_result_type res;
      logic            did_scroll;
      res        = '0;
      did_scroll = 1'b0;
      if (kind == KIND_PUT) begin
         case (ch)
            CH_BACKSPACE: begin
               if (cursor_pos > 0) begin
                  cursor_pos--;
                  screen_image[cursor_pos] = CH_SPACE;
               end
            end
            CH_NEWLINE: begin
               cursor_pos += COLS;
               cursor_pos -= cursor_pos % COLS;
               scroll_if_past_end(did_scroll);
            end
            CH_RETURN: cursor_pos -= cursor_pos % COLS;
            CH_TAB: begin
               for (int k = 0; k < TAB_SPACES; k++)
                  store_char(CH_SPACE, did_scroll);
            end
            default: store_char(ch, did_scroll);
         endcase
      end else if (addr < SCREEN_SIZE) begin
         res.cell_value = screen_image[addr];
      end
      res.cursor_position = cursor_pos[ADDR_FIELD_W-1:0];
      res.scrolled        = did_scroll;
      return res;
   endfunction

   function automatic char_type random_glyph();
      if ($urandom_range(7) == 0)
         return char_type'($urandom_range(128, 255));
      return char_type'($urandom_range(32, 126));
   endfunction

   // Offer one transaction, hold it until accepted, then predict its response
   task automatic send_item(input logic kind, input char_type ch, input addr_field_type addr);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_char_code    <= ch;
      req_cell_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(console_step(kind, ch, addr));
      items_sent++;
   endtask

   task automatic put_char(input char_type ch);
      send_item(KIND_PUT, ch, addr_field_type'($urandom_range(ADDR_FIELD_MAX)));
   endtask

   task automatic read_cell(input addr_field_type addr);
      send_item(KIND_READ, char_type'($urandom_range(255)), addr);
   endtask

   // Drop valid and wait until every predicted response has arrived
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Fresh screen reads zero, reads past the end give zero, backspace at origin holds
   task automatic test_reset_state();
      read_cell(addr_field_type'(0));
      read_cell(addr_field_type'(SCREEN_SIZE - 1));
      read_cell(addr_field_type'(SCREEN_SIZE));
      read_cell(ADDR_FIELD_MAX);
      put_char(CH_BACKSPACE);
      wait_for_results();
   endtask

   // Plain bytes at both extremes and every control code on the top rows
   task automatic test_control_codes();
      put_char("A");
      put_char(8'hFF);
      put_char(CH_NUL);
      put_char(CH_BACKSPACE);
      put_char(CH_TAB);
      put_char(CH_RETURN);
      put_char(CH_TAB);
      put_char(CH_NEWLINE);
      // Backspace at column 0 wraps to the end of the row above
      put_char(CH_BACKSPACE);
      for (int a = 0; a < 5; a++)
         read_cell(addr_field_type'(a));
      read_cell(addr_field_type'(COLS - 1));
      read_cell(addr_field_type'(COLS));
      wait_for_results();
   endtask

   // Reach the bottom row, then scroll by a tab and by a newline
   task automatic test_scroll_up();
      while (cursor_pos / COLS < ROWS - 1)
         put_char(CH_NEWLINE);
      for (int c = cursor_pos % COLS; c < COLS - 2; c++)
         put_char(char_type'(33 + c % 90));
      put_char(CH_TAB);
      read_cell(addr_field_type'(SCREEN_SIZE - COLS - 1));
      read_cell(addr_field_type'(SCREEN_SIZE - COLS));
      read_cell(addr_field_type'(SCREEN_SIZE - 1));
      put_char(CH_NEWLINE);
      put_char(CH_BACKSPACE);
      read_cell(addr_field_type'(0));
      wait_for_results();
   endtask

   // Stall the response side while requests keep coming, then drain
   task automatic test_backpressure();
      @(posedge clock);
      hold_off_cycles = HOLD_OFF_LEN;
      for (int n = 0; n < 40; n++) begin
         if (n % 5 == 4)
            read_cell(addr_field_type'((cursor_pos + SCREEN_SIZE - 1) % SCREEN_SIZE));
         else
            put_char(random_glyph());
      end
      wait_for_results();
   endtask

   // Console-like traffic: text lines, control bursts, reads and raw noise
   task automatic test_random_console();
      int stop_at;
      int pick;
      int len;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         idle_on = !(items_sent > stop_at - 1100 && items_sent < stop_at - 800);
         pick    = $urandom_range(99);
         if (pick < 40) begin
            // Line of text, usually short, sometimes past the row width
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
            repeat (len) put_char(random_glyph());
            case ($urandom_range(3))
               0, 1: put_char(CH_NEWLINE);
               2: put_char(CH_RETURN);
               default: ;
            endcase
         end else if (pick < 52) begin
            repeat ($urandom_range(1, 8)) put_char(CH_NEWLINE);
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 4)) put_char(CH_TAB);
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 6)) put_char(CH_BACKSPACE);
         end else if (pick < 88) begin
            // Read mostly just behind the cursor, sometimes anywhere in the field
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(2) != 0)
                  read_cell(addr_field_type'((cursor_pos + SCREEN_SIZE
                                              - $urandom_range(1, 2 * COLS)) % SCREEN_SIZE));
               else
                  read_cell(addr_field_type'($urandom_range(ADDR_FIELD_MAX)));
            end
         end else begin
            send_item(1'($urandom_range(1)), char_type'($urandom_range(255)),
                      addr_field_type'($urandom_range(ADDR_FIELD_MAX)));
         end
      end
      idle_on = 1'b1;
   endtask

   // Drive response ready: long hold-off when asked, otherwise random idling
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Check each response transaction against the oldest prediction
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: cell_value %0d cursor %0d scrolled %0d",
                     $time, rsp_cell_value, rsp_cursor_position, rsp_scrolled);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_cell_value !== want.cell_value) begin
               $display("%0t: cell_value mismatch: expected %0d, actual %0d",
                        $time, want.cell_value, rsp_cell_value);
               error_count++;
            end
            if (rsp_cursor_position !== want.cursor_position) begin
               $display("%0t: cursor_position mismatch: expected %0d, actual %0d",
                        $time, want.cursor_position, rsp_cursor_position);
               error_count++;
            end
            if (rsp_scrolled !== want.scrolled) begin
               $display("%0t: scrolled mismatch: expected %0d, actual %0d",
                        $time, want.scrolled, rsp_scrolled);
               error_count++;
            end
         end
      end
   end

   // End the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < SCREEN_SIZE; i++)
         screen_image[i] = CH_NUL;
      cursor_pos = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_control_codes();
      test_scroll_up();
      test_backpressure();
      test_random_console();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
